FILE: sv/colle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colle_pkg
// Shared types and codes of the circular ordered list engine.
// ----------------------------------------------------------------------------
package colle_pkg;

  localparam logic [2:0] OP_INS_START = 3'd0;
  localparam logic [2:0] OP_INS_POS   = 3'd1;
  localparam logic [2:0] OP_INS_END   = 3'd2;
  localparam logic [2:0] OP_DELETE    = 3'd3;
  localparam logic [2:0] OP_DUMP      = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] item_value;
    logic [7:0]         position;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic               last;
    logic [5:0]         count;
  } out_t;

  // write enables from the sequencer to the slot store
  typedef struct packed {
    logic val_we;
    logic nxt_we;
    logic prv_we;
    logic free_we;
  } wr_en_t;

endpackage

FILE: sv/colle_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colle_store
// Slot pool: values, next and previous links, and the free slot stack.
// ----------------------------------------------------------------------------
module colle_store #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rd_en,
  input  logic [$clog2(CAPACITY)-1:0]      rd_slot,
  output logic [VALUE_WIDTH-1:0]           rd_val,
  output logic [$clog2(CAPACITY)-1:0]      rd_nxt,
  output logic [$clog2(CAPACITY)-1:0]      rd_prv,
  input  logic                             fr_en,
  input  logic [$clog2(CAPACITY)-1:0]      fr_idx,
  output logic [$clog2(CAPACITY)-1:0]      fr_q,
  input  colle_pkg::wr_en_t                wr,
  input  logic [$clog2(CAPACITY)-1:0]      val_addr,
  input  logic [VALUE_WIDTH-1:0]           val_data,
  input  logic [$clog2(CAPACITY)-1:0]      nxt_addr,
  input  logic [$clog2(CAPACITY)-1:0]      nxt_data,
  input  logic [$clog2(CAPACITY)-1:0]      prv_addr,
  input  logic [$clog2(CAPACITY)-1:0]      prv_data,
  input  logic [$clog2(CAPACITY)-1:0]      fw_idx,
  input  logic [$clog2(CAPACITY)-1:0]      fw_data
);
  import colle_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam logic [SW-1:0] TOP_IDX = SW'(CAPACITY - 1);

  logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
  logic [SW-1:0]          nxt_mem  [CAPACITY];
  logic [SW-1:0]          prv_mem  [CAPACITY];
  logic [SW-1:0]          free_mem [CAPACITY];
  logic [CAPACITY-1:0]    free_vld_r;
  logic [SW-1:0]          fr_raw_r;
  logic                   fr_hit_r;
  logic [SW-1:0]          fr_idx_r;

  always_ff @(posedge clk) begin
    if (wr.val_we) val_mem[val_addr] <= val_data;
    if (wr.nxt_we) nxt_mem[nxt_addr] <= nxt_data;
    if (wr.prv_we) prv_mem[prv_addr] <= prv_data;
    if (wr.free_we) free_mem[fw_idx] <= fw_data;
    if (rd_en) begin
      rd_val <= val_mem[rd_slot];
      rd_nxt <= nxt_mem[rd_slot];
      rd_prv <= prv_mem[rd_slot];
    end
    if (fr_en) begin
      fr_raw_r <= free_mem[fr_idx];
      fr_idx_r <= fr_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_vld_r <= '0;
      fr_hit_r   <= 1'b0;
    end else begin
      if (wr.free_we) free_vld_r[fw_idx] <= 1'b1;
      if (fr_en) fr_hit_r <= free_vld_r[fr_idx];
    end
  end

  // an untouched stack entry holds its reset slot number
  assign fr_q = fr_hit_r ? fr_raw_r : (TOP_IDX - fr_idx_r);

endmodule

FILE: sv/colle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colle_ctrl
// Sequencer: decodes a transaction and walks the linked slots one read a step.
// ----------------------------------------------------------------------------
module colle_ctrl #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  colle_pkg::in_t                   in_data,
  output logic                             in_stall,
  input  logic                             out_free,
  output logic                             emit_go,
  output colle_pkg::out_t                  emit_data,
  output logic                             rd_en,
  output logic [$clog2(CAPACITY)-1:0]      rd_slot,
  input  logic [VALUE_WIDTH-1:0]           rd_val,
  input  logic [$clog2(CAPACITY)-1:0]      rd_nxt,
  input  logic [$clog2(CAPACITY)-1:0]      rd_prv,
  output logic                             fr_en,
  output logic [$clog2(CAPACITY)-1:0]      fr_idx,
  input  logic [$clog2(CAPACITY)-1:0]      fr_q,
  output colle_pkg::wr_en_t                wr,
  output logic [$clog2(CAPACITY)-1:0]      val_addr,
  output logic [VALUE_WIDTH-1:0]           val_data,
  output logic [$clog2(CAPACITY)-1:0]      nxt_addr,
  output logic [$clog2(CAPACITY)-1:0]      nxt_data,
  output logic [$clog2(CAPACITY)-1:0]      prv_addr,
  output logic [$clog2(CAPACITY)-1:0]      prv_data,
  output logic [$clog2(CAPACITY)-1:0]      fw_idx,
  output logic [$clog2(CAPACITY)-1:0]      fw_data
);
  import colle_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [CW-1:0] CAP_M1 = CW'(CAPACITY - 1);
  localparam logic [CW-1:0] ONE_C  = CW'(1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_ALLOC  = 4'd2;
  localparam logic [3:0] S_ALLOC2 = 4'd3;
  localparam logic [3:0] S_WALK   = 4'd4;
  localparam logic [3:0] S_WALKW  = 4'd5;
  localparam logic [3:0] S_LINK1  = 4'd6;
  localparam logic [3:0] S_LINK2  = 4'd7;
  localparam logic [3:0] S_LINK3  = 4'd8;
  localparam logic [3:0] S_SINGLE = 4'd9;
  localparam logic [3:0] S_SRCH   = 4'd10;
  localparam logic [3:0] S_SCHK   = 4'd11;
  localparam logic [3:0] S_DRD    = 4'd12;
  localparam logic [3:0] S_DOUT   = 4'd13;
  localparam logic [3:0] S_EMIT   = 4'd14;

  logic [3:0]             state_r, state_nxt;
  logic [2:0]             op_r, op_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [7:0]             pos_r, pos_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [SW-1:0]          head_r, head_nxt;
  logic [SW-1:0]          a_r, a_nxt;
  logic [SW-1:0]          s_r, s_nxt;
  logic [CW-1:0]          i_r, i_nxt;
  logic [2:0]             st_r, st_nxt;
  logic                   mkhead_r, mkhead_nxt;
  logic                   walk_r, walk_nxt;
  logic [63:0]            in_ext;
  logic [63:0]            rd_ext;
  logic                   cnt_full;

  assign in_ext   = 64'(in_data.item_value);
  assign rd_ext   = 64'(signed'(rd_val));
  assign cnt_full = (cnt_r == CAP_C);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    a_nxt      = a_r;
    s_nxt      = s_r;
    i_nxt      = i_r;
    st_nxt     = st_r;
    mkhead_nxt = mkhead_r;
    walk_nxt   = walk_r;
    rd_en      = 1'b0;
    rd_slot    = s_r;
    fr_en      = 1'b0;
    fr_idx     = SW'(CAP_M1 - cnt_r);
    wr         = '0;
    val_addr   = fr_q;
    val_data   = val_r;
    nxt_addr   = s_r;
    nxt_data   = s_r;
    prv_addr   = s_r;
    prv_data   = s_r;
    fw_idx     = SW'(CAP_C - cnt_r);
    fw_data    = s_r;
    emit_go    = 1'b0;
    emit_data  = '{status: st_r, element: '0, last: 1'b1, count: 6'(cnt_r)};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          val_nxt   = in_ext[VALUE_WIDTH-1:0];
          pos_nxt   = in_data.position;
          st_nxt    = ST_OK;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        mkhead_nxt = 1'b0;
        walk_nxt   = 1'b0;
        i_nxt      = '0;
        s_nxt      = head_r;
        state_nxt  = S_EMIT;
        case (op_r)
          OP_INS_START, OP_INS_END: begin
            if (cnt_full) begin
              st_nxt = ST_FULL;
            end else begin
              mkhead_nxt = (op_r == OP_INS_START);
              state_nxt  = S_ALLOC;
            end
          end
          OP_INS_POS: begin
            if (pos_r == 8'd0) begin
              st_nxt = ST_INVALID;
            end else if (cnt_full) begin
              st_nxt = ST_FULL;
            end else if (pos_r == 8'd1) begin
              mkhead_nxt = 1'b1;
              state_nxt  = S_ALLOC;
            end else if ((9'(pos_r) - 9'd1) > 9'(cnt_r)) begin
              st_nxt = ST_RANGE;
            end else begin
              walk_nxt  = 1'b1;
              i_nxt     = CW'(pos_r - 8'd2);
              state_nxt = S_ALLOC;
            end
          end
          OP_DELETE: begin
            if (cnt_r == '0) st_nxt = ST_EMPTY;
            else state_nxt = S_SRCH;
          end
          OP_DUMP: begin
            if (cnt_r == '0) st_nxt = ST_EMPTY;
            else state_nxt = S_DRD;
          end
          default: begin
            st_nxt = ST_OK;
          end
        endcase
      end
      S_ALLOC: begin
        fr_en     = 1'b1;
        rd_en     = 1'b1;
        rd_slot   = head_r;
        state_nxt = S_ALLOC2;
      end
      S_ALLOC2: begin
        s_nxt     = fr_q;
        wr.val_we = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_SINGLE;
        end else if (walk_r) begin
          a_nxt     = head_r;
          state_nxt = S_WALK;
        end else begin
          // tail sits just before the head
          a_nxt     = rd_prv;
          state_nxt = S_LINK1;
        end
      end
      S_WALK: begin
        if (i_r == '0) begin
          state_nxt = S_LINK1;
        end else begin
          rd_en     = 1'b1;
          rd_slot   = a_r;
          state_nxt = S_WALKW;
        end
      end
      S_WALKW: begin
        a_nxt     = rd_nxt;
        i_nxt     = i_r - ONE_C;
        state_nxt = S_WALK;
      end
      S_LINK1: begin
        rd_en     = 1'b1;
        rd_slot   = a_r;
        state_nxt = S_LINK2;
      end
      S_LINK2: begin
        wr.nxt_we = 1'b1;
        nxt_addr  = s_r;
        nxt_data  = rd_nxt;
        wr.prv_we = 1'b1;
        prv_addr  = rd_nxt;
        prv_data  = s_r;
        state_nxt = S_LINK3;
      end
      S_LINK3: begin
        wr.nxt_we = 1'b1;
        nxt_addr  = a_r;
        nxt_data  = s_r;
        wr.prv_we = 1'b1;
        prv_addr  = s_r;
        prv_data  = a_r;
        if (mkhead_r) head_nxt = s_r;
        cnt_nxt   = cnt_r + ONE_C;
        state_nxt = S_EMIT;
      end
      S_SINGLE: begin
        wr.nxt_we = 1'b1;
        wr.prv_we = 1'b1;
        head_nxt  = s_r;
        cnt_nxt   = cnt_r + ONE_C;
        state_nxt = S_EMIT;
      end
      S_SRCH: begin
        rd_en     = 1'b1;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (rd_val == val_r) begin
          wr.nxt_we  = 1'b1;
          nxt_addr   = rd_prv;
          nxt_data   = rd_nxt;
          wr.prv_we  = 1'b1;
          prv_addr   = rd_nxt;
          prv_data   = rd_prv;
          wr.free_we = 1'b1;
          cnt_nxt    = cnt_r - ONE_C;
          if (cnt_r == ONE_C) head_nxt = '0;
          else if (s_r == head_r) head_nxt = rd_nxt;
          state_nxt  = S_EMIT;
        end else if ((i_r + ONE_C) == cnt_r) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_EMIT;
        end else begin
          i_nxt     = i_r + ONE_C;
          s_nxt     = rd_nxt;
          state_nxt = S_SRCH;
        end
      end
      S_DRD: begin
        rd_en     = 1'b1;
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        emit_data.status  = ST_OK;
        emit_data.element = signed'(rd_ext[31:0]);
        emit_data.last    = ((i_r + ONE_C) == cnt_r);
        if (out_free) begin
          emit_go = 1'b1;
          if ((i_r + ONE_C) == cnt_r) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + ONE_C;
            s_nxt     = rd_nxt;
            state_nxt = S_DRD;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit_go   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    a_r      <= a_nxt;
    s_r      <= s_nxt;
    i_r      <= i_nxt;
    st_r     <= st_nxt;
    mkhead_r <= mkhead_nxt;
    walk_r   <= walk_nxt;
  end

endmodule

FILE: sv/circular_ordered_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_ordered_list_engine_unit
// Circular doubly linked list of signed values kept in a pool of slots.
// ----------------------------------------------------------------------------
// Usage: one transaction on in_ carries an opcode, a value and a position.
// Inserts, delete and unused opcodes give one result on out_; a dump of a
// non-empty list gives one result per element, head first, with last set on
// the final one. in_stall is high from acceptance until the final result of
// the transaction has been loaded into the output register, so items are
// handled one at a time; the next item can be taken while that result waits.
// An insert at position p above 1 walks from the head to the slot before p,
// and a delete searches from the head slot by slot. The sequencer returns to
// idle as the final result is loaded. The pace of a list walk is set by the
// single registered read port of the slot store, which every step of a walk
// goes through.
// Reset empties the list at once; the free slot stack reads as its reset
// order until entries are written, so there is no clearing pass.
// A stalled receiver holds the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module circular_ordered_list_engine_unit #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  colle_pkg::in_t  in_data,
  output logic            in_stall,
  output logic            out_valid,
  output colle_pkg::out_t out_data,
  input  logic            out_stall
);
  import colle_pkg::*;

  localparam int SW = $clog2(CAPACITY);

  logic                   out_valid_r;
  out_t                   out_data_r;
  logic                   out_free;
  logic                   emit_go;
  out_t                   emit_data;
  logic                   rd_en;
  logic [SW-1:0]          rd_slot;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [SW-1:0]          rd_nxt;
  logic [SW-1:0]          rd_prv;
  logic                   fr_en;
  logic [SW-1:0]          fr_idx;
  logic [SW-1:0]          fr_q;
  wr_en_t                 wr;
  logic [SW-1:0]          val_addr;
  logic [VALUE_WIDTH-1:0] val_data;
  logic [SW-1:0]          nxt_addr;
  logic [SW-1:0]          nxt_data;
  logic [SW-1:0]          prv_addr;
  logic [SW-1:0]          prv_data;
  logic [SW-1:0]          fw_idx;
  logic [SW-1:0]          fw_data;

  assign out_free = !out_valid_r || !out_stall;

  colle_ctrl #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_free(out_free), .emit_go(emit_go), .emit_data(emit_data),
    .rd_en(rd_en), .rd_slot(rd_slot), .rd_val(rd_val), .rd_nxt(rd_nxt),
    .rd_prv(rd_prv), .fr_en(fr_en), .fr_idx(fr_idx), .fr_q(fr_q), .wr(wr),
    .val_addr(val_addr), .val_data(val_data), .nxt_addr(nxt_addr),
    .nxt_data(nxt_data), .prv_addr(prv_addr), .prv_data(prv_data),
    .fw_idx(fw_idx), .fw_data(fw_data)
  );

  colle_store #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_store (
    .clk(clk), .rst_n(rst_n),
    .rd_en(rd_en), .rd_slot(rd_slot), .rd_val(rd_val), .rd_nxt(rd_nxt),
    .rd_prv(rd_prv), .fr_en(fr_en), .fr_idx(fr_idx), .fr_q(fr_q), .wr(wr),
    .val_addr(val_addr), .val_data(val_data), .nxt_addr(nxt_addr),
    .nxt_data(nxt_data), .prv_addr(prv_addr), .prv_data(prv_data),
    .fw_idx(fw_idx), .fw_data(fw_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) out_data_r <= emit_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_emit_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !emit_go)
    else $error("result emitted in the cycle a transaction was accepted");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer not busy after accepting a transaction");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.last))
    else $error("error status on a result that is not the last");

  a_element_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.element == '0))
    else $error("non-zero element with an error status");

endmodule
